// ===== src/irc_fse_pkg.sv =====
// ----------------------------------------------------------------------------
// irc_fse_pkg
// Types, constants and helper functions shared by the formatting-code
// stripper and markup escaper.
// ----------------------------------------------------------------------------
package irc_fse_pkg;

   localparam int QDepth = 4;
   localparam int QAddrW = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   localparam logic [7:0] ChColor   = 8'h03;
   localparam logic [7:0] ChBold    = 8'h02;
   localparam logic [7:0] ChBlink   = 8'h06;
   localparam logic [7:0] ChPlain   = 8'h0f;
   localparam logic [7:0] ChReverse = 8'h16;
   localparam logic [7:0] ChItalic  = 8'h1d;
   localparam logic [7:0] ChUnder   = 8'h1f;
   localparam logic [7:0] ChNul     = 8'h00;
   localparam logic [7:0] ChComma   = 8'h2c;
   localparam logic [7:0] ChZero    = 8'h30;
   localparam logic [7:0] ChAmp     = 8'h26;
   localparam logic [7:0] ChLt      = 8'h3c;
   localparam logic [7:0] ChGt      = 8'h3e;
   localparam logic [7:0] ChApos    = 8'h27;
   localparam logic [7:0] ChQuot    = 8'h22;
   localparam logic [7:0] ChSemi    = 8'h3b;
   localparam logic [7:0] ChLowA    = 8'h61;
   localparam logic [7:0] Radix     = 8'd10;
   localparam logic [1:0] MaxDigits = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_FG    = 4'b0010,
      PH_COMMA = 4'b0100,
      PH_BG    = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      K_NONE = 2'd0,
      K_BYTE = 2'd1,
      K_ENT  = 2'd2,
      K_HEX  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       pre_comma;
      logic       post_comma;
      logic       last;
   } desc_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= ChZero) && (b < ChZero + Radix);
   endfunction

   function automatic logic is_strip(input logic [7:0] b);
      return b inside {ChBold, ChBlink, ChPlain, ChReverse, ChItalic, ChUnder, ChNul};
   endfunction

   function automatic logic is_entity(input logic [7:0] b);
      return b inside {ChAmp, ChLt, ChGt, ChApos, ChQuot};
   endfunction

   function automatic logic is_ctrl(input logic [7:0] b);
      return b inside {[8'h01:8'h08], 8'h0b, 8'h0c, [8'h0e:8'h1f]};
   endfunction

   function automatic logic [2:0] utf8_extra(input logic [7:0] b);
      logic [2:0] n;
      n = 3'd0;
      if (b inside {[8'hc0:8'hdf]}) n = 3'd1;
      else if (b inside {[8'he0:8'hef]}) n = 3'd2;
      else if (b inside {[8'hf0:8'hf7]}) n = 3'd3;
      else if (b inside {[8'hf8:8'hfb]}) n = 3'd4;
      else if (b inside {[8'hfc:8'hfd]}) n = 3'd5;
      return n;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) c = ChZero + {4'd0, d};
      else c = ChLowA + {4'd0, d} - 8'd10;
      return c;
   endfunction

   function automatic logic [2:0] body_len(input kind_type kind, input logic [7:0] b);
      logic [2:0] n;
      case (kind)
         K_NONE: n = 3'd0;
         K_BYTE: n = 3'd1;
         K_ENT: begin
            case (b)
               ChAmp:   n = 3'd5;
               ChLt:    n = 3'd4;
               ChGt:    n = 3'd4;
               default: n = 3'd6;
            endcase
         end
         K_HEX:   n = (b >= 8'h10) ? 3'd6 : 3'd5;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   // character k of the expansion, strings left-justified in 48 bits
   function automatic logic [7:0] body_byte(input kind_type kind, input logic [7:0] b,
                                            input logic [2:0] k);
      logic [47:0] s;
      logic [7:0]  c;
      case (kind)
         K_ENT: begin
            case (b)
               ChAmp:   s = {"&amp;", 8'h00};
               ChLt:    s = {"&lt;", 16'h0000};
               ChGt:    s = {"&gt;", 16'h0000};
               ChApos:  s = "&apos;";
               default: s = "&quot;";
            endcase
         end
         K_HEX: begin
            if (b >= 8'h10) s = {"&#x", hex_char(b[7:4]), hex_char(b[3:0]), ChSemi};
            else s = {"&#x", hex_char(b[3:0]), ChSemi, 8'h00};
         end
         default: s = {b, 40'd0};
      endcase
      c = s[47 - 8 * k -: 8];
      return c;
   endfunction

endpackage

// ===== src/irc_fse_front.sv =====
// ----------------------------------------------------------------------------
// irc_fse_front
// Takes input words, tracks color-code and utf-8 state and classifies each
// byte into a descriptor for the expansion stage.
// ----------------------------------------------------------------------------
module irc_fse_front
   import irc_fse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output logic       push,
   output desc_type   desc
);

   phase_type  phase_ff, phase_in;
   logic [1:0] count_ff, count_in;
   logic [2:0] utf_ff, utf_in;
   logic       plain;
   logic       pre;
   logic       post;
   kind_type   kind;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      utf_in   = utf_ff;
      plain    = 1'b0;
      pre      = 1'b0;
      kind     = K_NONE;
      if (utf_ff != 3'd0) begin
         utf_in = utf_ff - 3'd1;
         kind   = K_BYTE;
      end else begin
         case (phase_ff)
            PH_FG: begin
               if (is_digit(in_byte) && (count_ff < MaxDigits)) begin
                  count_in = count_ff + 2'd1;
               end else if (in_byte == ChComma) begin
                  phase_in = PH_COMMA;
               end else begin
                  phase_in = PH_IDLE;
                  plain    = 1'b1;
               end
            end
            PH_COMMA: begin
               if (is_digit(in_byte)) begin
                  phase_in = PH_BG;
                  count_in = 2'd1;
               end else begin
                  phase_in = PH_IDLE;
                  pre      = 1'b1;
                  plain    = 1'b1;
               end
            end
            PH_BG: begin
               if (is_digit(in_byte) && (count_ff < MaxDigits)) begin
                  count_in = count_ff + 2'd1;
                  if (count_ff + 2'd1 >= MaxDigits) phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_IDLE;
                  plain    = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               plain    = 1'b1;
            end
         endcase
      end
      if (plain) begin
         if (in_byte == ChColor) begin
            phase_in = PH_FG;
            count_in = 2'd0;
         end else if (!is_strip(in_byte)) begin
            if (in_byte[7]) begin
               utf_in = utf8_extra(in_byte);
               kind   = K_BYTE;
            end else if (is_entity(in_byte)) begin
               kind = K_ENT;
            end else if (is_ctrl(in_byte)) begin
               kind = K_HEX;
            end else begin
               kind = K_BYTE;
            end
         end
      end
      post = in_last && (phase_in == PH_COMMA);
      if (in_last) begin
         phase_in = PH_IDLE;
         count_in = 2'd0;
         utf_in   = 3'd0;
      end
   end

   assign desc.data       = in_byte;
   assign desc.kind       = kind;
   assign desc.pre_comma  = pre;
   assign desc.post_comma = post;
   assign desc.last       = in_last;
   assign push = accept && ((kind != K_NONE) || pre || post || in_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= 2'd0;
         utf_ff   <= 3'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         utf_ff   <= utf_in;
      end
   end

endmodule

// ===== src/irc_fse_queue.sv =====
// ----------------------------------------------------------------------------
// irc_fse_queue
// Short descriptor queue between the classifier and the expansion stage.
// ----------------------------------------------------------------------------
module irc_fse_queue
   import irc_fse_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output desc_type head,
   output logic     head_valid,
   output logic     full
);

   desc_type          mem_ff [QDepth];
   logic [QAddrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAddrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]  count_ff, count_in;

   assign head       = mem_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == QCntW'(QDepth));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QAddrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QAddrW'(1) : rd_ptr_ff;
      count_in  = count_ff + QCntW'(push) - QCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== src/irc_fse_back.sv =====
// ----------------------------------------------------------------------------
// irc_fse_back
// Expands one descriptor into its output words, one per cycle while the
// receiver is ready, into a registered output stage.
// ----------------------------------------------------------------------------
module irc_fse_back
   import irc_fse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  desc_type   head,
   input  logic       head_valid,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] out_byte
   output logic [1:0] rsp_tuser,  // [0] has_byte, [1] run_last
   output logic       rsp_tlast
);

   logic [2:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       has_ff, has_in;
   logic       run_ff, run_in;
   logic       eot_ff, eot_in;
   logic [2:0] blen;
   logic [2:0] pre;
   logic [2:0] k;
   logic [2:0] total_raw;
   logic [2:0] total;
   logic       is_end;
   logic       load;

   always_comb begin
      blen      = body_len(head.kind, head.data);
      pre       = {2'b00, head.pre_comma};
      k         = pos_ff - pre;
      total_raw = pre + blen + {2'b00, head.post_comma};
      total     = (total_raw == 3'd0) ? 3'd1 : total_raw;
      is_end    = (pos_ff == total - 3'd1);
      load      = head_valid && (!valid_ff || rsp_tready);
      pop       = load && is_end;

      has_in = 1'b1;
      if (head.pre_comma && (pos_ff == 3'd0)) begin
         data_in = ChComma;
      end else if (k < blen) begin
         data_in = body_byte(head.kind, head.data, k);
      end else if (head.post_comma) begin
         data_in = ChComma;
      end else begin
         data_in = 8'h00;
         has_in  = 1'b0;
      end
      run_in = is_end;
      eot_in = is_end && head.last;

      if (load) pos_in = is_end ? 3'd0 : pos_ff + 3'd1;
      else pos_in = pos_ff;

      if (load) valid_in = 1'b1;
      else if (rsp_tready) valid_in = 1'b0;
      else valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         has_ff  <= has_in;
         run_ff  <= run_in;
         eot_ff  <= eot_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = {run_ff, has_ff};
   assign rsp_tlast  = eot_ff;

endmodule

// ===== src/irc_format_strip_escape.sv =====
// ----------------------------------------------------------------------------
// irc_format_strip_escape
// Chat text formatting-code stripper with markup escaping.
// ----------------------------------------------------------------------------
// The req stream carries one text byte per word, with req_tlast on the
// final byte of a fragment. Formatting and color codes are dropped, markup
// characters and controls are expanded to entities, utf-8 sequences pass.
// The rsp stream carries one output byte per word; rsp_tuser[0] is clear
// on a bare end marker, rsp_tuser[1] marks the last word caused by one
// input byte and rsp_tlast the last word of the fragment.
// The first word of an input byte passes through the queue and then the
// registered output stage. Plain bytes flow at one word per cycle while
// the receiver is ready; a byte that expands to n words (up to 7) holds
// the expansion stage while its output sequencer sends them. A four-entry
// queue decouples the classifier, so req_tready only drops when it fills.
// When the receiver stalls, the output word holds and the queue fills.
// Reset empties the queue and output stage and clears the color and utf-8
// state.
// ----------------------------------------------------------------------------
module irc_format_strip_escape
   import irc_fse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] out_byte
   output logic [1:0] rsp_tuser,  // [0] has_byte, [1] run_last
   output logic       rsp_tlast
);

   logic     full;
   logic     accept;
   logic     push;
   desc_type push_desc;
   desc_type head;
   logic     head_valid;
   logic     pop;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   irc_fse_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .push    (push),
      .desc    (push_desc)
   );

   irc_fse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (full)
   );

   irc_fse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== bench/irc_format_strip_escape_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// irc_format_strip_escape_test
// Self-checking bench for the chat text stripper and markup escaper.
// ----------------------------------------------------------------------------
// Text fragments go in one byte per word. A scoreboard tracks the color and
// utf-8 state, builds the expected output words for each accepted byte and
// checks every output word in order. A short directed opening is followed
// by random fragments made of color codes, entities, controls and utf-8
// sequences, with random idling on both sides, a long receiver stall and a
// full drain in the middle of the run.
// ----------------------------------------------------------------------------
module irc_format_strip_escape_test;
   import irc_fse_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       run_last;
      logic       end_text;
   } text_word_type;

   class escape_board_type;
      phase_type     phase;
      bit [1:0]      digits;
      bit [2:0]      utf_left;
      text_word_type step[$];
      text_word_type due_words[$];
      int            errors;

      function new();
         clear();
         errors = 0;
      endfunction

      function void clear();
         phase    = PH_IDLE;
         digits   = 2'd0;
         utf_left = 3'd0;
      endfunction

      function bit is_dec(logic [7:0] b);
         return (b >= ChZero) && (b <= ChZero + 8'd9);
      endfunction

      function bit [2:0] lead_extra(logic [7:0] b);
         if (b >= 8'hc0 && b <= 8'hdf) return 3'd1;
         if (b >= 8'he0 && b <= 8'hef) return 3'd2;
         if (b >= 8'hf0 && b <= 8'hf7) return 3'd3;
         if (b >= 8'hf8 && b <= 8'hfb) return 3'd4;
         if (b >= 8'hfc && b <= 8'hfd) return 3'd5;
         return 3'd0;
      endfunction

      function void put(logic [7:0] b);
         text_word_type w;
         w.data     = b;
         w.has_byte = 1'b1;
         w.run_last = 1'b0;
         w.end_text = 1'b0;
         step.push_back(w);
      endfunction

      function void put_text(string s);
         for (int i = 0; i < s.len(); i++) put(s[i]);
      endfunction

      function void take_plain(logic [7:0] b);
         string hexset;
         hexset = "0123456789abcdef";
         if (b == ChColor) begin
            phase  = PH_FG;
            digits = 2'd0;
         end else if (b == ChBold || b == ChItalic || b == ChUnder || b == ChBlink ||
                      b == ChReverse || b == ChPlain || b == ChNul) begin
            // formatting codes vanish
         end else if (b >= 8'h80) begin
            utf_left = lead_extra(b);
            put(b);
         end else if (b == ChAmp) begin
            put_text("&amp;");
         end else if (b == ChLt) begin
            put_text("&lt;");
         end else if (b == ChGt) begin
            put_text("&gt;");
         end else if (b == ChApos) begin
            put_text("&apos;");
         end else if (b == ChQuot) begin
            put_text("&quot;");
         end else if ((b >= 8'h01 && b <= 8'h08) || b == 8'h0b || b == 8'h0c ||
                      (b >= 8'h0e && b <= 8'h1f)) begin
            put_text("&#x");
            if (b >= 8'h10) put(hexset[b[7:4]]);
            put(hexset[b[3:0]]);
            put(ChSemi);
         end else begin
            put(b);
         end
      endfunction

      function void note_byte(logic [7:0] b, logic lst);
         text_word_type w;
         step.delete();
         if (utf_left != 3'd0) begin
            utf_left--;
            put(b);
         end else begin
            case (phase)
               PH_FG: begin
                  if (is_dec(b) && digits < MaxDigits) digits++;
                  else if (b == ChComma) phase = PH_COMMA;
                  else begin
                     phase = PH_IDLE;
                     take_plain(b);
                  end
               end
               PH_COMMA: begin
                  if (is_dec(b)) begin
                     phase  = PH_BG;
                     digits = 2'd1;
                  end else begin
                     phase = PH_IDLE;
                     put(ChComma);
                     take_plain(b);
                  end
               end
               PH_BG: begin
                  if (is_dec(b) && digits < MaxDigits) begin
                     digits++;
                     if (digits >= MaxDigits) phase = PH_IDLE;
                  end else begin
                     phase = PH_IDLE;
                     take_plain(b);
                  end
               end
               default: begin
                  phase = PH_IDLE;
                  take_plain(b);
               end
            endcase
         end
         if (lst) begin
            if (phase == PH_COMMA) put(ChComma);
            clear();
            if (step.size() == 0) begin
               // bare end marker
               w = '0;
               step.push_back(w);
            end
            w = step.pop_back();
            w.end_text = 1'b1;
            step.push_back(w);
         end
         if (step.size() != 0) begin
            w = step.pop_back();
            w.run_last = 1'b1;
            step.push_back(w);
         end
         foreach (step[i]) due_words.push_back(step[i]);
      endfunction

      function void check_word(logic [7:0] data, logic [1:0] user, logic lst);
         text_word_type w;
         if (due_words.size() == 0) begin
            $display("%0t: unexpected word data %h has_byte %b run_last %b last %b",
                     $time, data, user[0], user[1], lst);
            errors++;
            return;
         end
         w = due_words.pop_front();
         if (w.data !== data || w.has_byte !== user[0] || w.run_last !== user[1] ||
             w.end_text !== lst) begin
            $display("%0t: mismatch expected data %h has_byte %b run_last %b last %b",
                     $time, w.data, w.has_byte, w.run_last, w.end_text);
            $display("%0t:          actual   data %h has_byte %b run_last %b last %b",
                     $time, data, user[0], user[1], lst);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   escape_board_type board = new();
   logic [7:0]  frag[$];
   bit          quiet = 1'b0;
   int          words_seen = 0;
   int          hold_left = 0;
   int          stall_left = 0;
   bit          held = 1'b0;

   irc_format_strip_escape dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   task automatic send_byte(input logic [7:0] b, input logic lst);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 3);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_byte(b, lst);
   endtask

   task automatic add_piece();
      int kind;
      int n;
      int k;
      logic [7:0] lead;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1: frag.push_back(8'($urandom_range(8'h20, 8'h7e)));
         2: begin
            case ($urandom_range(0, 4))
               0: frag.push_back(ChAmp);
               1: frag.push_back(ChLt);
               2: frag.push_back(ChGt);
               3: frag.push_back(ChApos);
               default: frag.push_back(ChQuot);
            endcase
         end
         3: frag.push_back(8'($urandom_range(0, 8'h1f)));
         4, 5: begin
            // color code, sometimes with too many digits or a bare comma
            frag.push_back(ChColor);
            n = $urandom_range(0, 3);
            repeat (n) frag.push_back(8'(ChZero + $urandom_range(0, 9)));
            if ($urandom_range(0, 2) != 0) begin
               frag.push_back(ChComma);
               n = $urandom_range(0, 3);
               repeat (n) frag.push_back(8'(ChZero + $urandom_range(0, 9)));
            end
         end
         6, 7: begin
            n = $urandom_range(1, 5);
            case (n)
               1: lead = 8'($urandom_range(8'hc0, 8'hdf));
               2: lead = 8'($urandom_range(8'he0, 8'hef));
               3: lead = 8'($urandom_range(8'hf0, 8'hf7));
               4: lead = 8'($urandom_range(8'hf8, 8'hfb));
               default: lead = 8'($urandom_range(8'hfc, 8'hfd));
            endcase
            frag.push_back(lead);
            k = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n) : n;
            repeat (k) frag.push_back(8'($urandom_range(8'h80, 8'hbf)));
         end
         8: frag.push_back(8'($urandom_range(0, 255)));
         default: begin
            case ($urandom_range(0, 5))
               0: frag.push_back(8'h09);
               1: frag.push_back(8'h0a);
               2: frag.push_back(8'h0d);
               3: frag.push_back(8'h7f);
               4: frag.push_back(ChComma);
               default: frag.push_back(8'(ChZero + $urandom_range(0, 9)));
            endcase
         end
      endcase
   endtask

   // receiver: random stalls, one long hold-off, output checks
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
            words_seen++;
         end
         if (!held && words_seen >= 150) begin
            held      = 1'b1;
            hold_left = 60;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int sent;
      int pieces;
      logic [8:0] opening[$];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // {last, byte}
      opening = '{9'h000, 9'h026, 9'h03c, 9'h022, 9'h001, 9'h01e, 9'h002,
                  9'h003, 9'h031, 9'h032, 9'h02c, 9'h033, 9'h034,
                  9'h003, 9'h02c, 9'h039, 9'h061,
                  9'h003, 9'h037, 9'h02c, 9'h02c,
                  9'h0fd, 9'h180,
                  9'h003, 9'h031, 9'h12c,
                  9'h11f,
                  9'h1ff};
      foreach (opening[i]) send_byte(opening[i][7:0], opening[i][8]);

      sent = opening.size();
      while (sent < 470) begin
         frag.delete();
         pieces = $urandom_range(1, 6);
         repeat (pieces) add_piece();
         for (int i = 0; i < frag.size(); i++) begin
            send_byte(frag[i], i == frag.size() - 1);
            sent++;
            if (sent == 200) begin
               // let everything drain before going on
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (board.due_words.size() != 0) @(posedge clock);
            end
            if (sent >= 400) quiet = 1'b1;
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.due_words.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (board.errors == 0) $display("irc_format_strip_escape_test: clean");
      else $display("irc_format_strip_escape_test: errors");
      $finish;
   end

   initial begin
      #400000;
      $display("irc_format_strip_escape_test: errors");
      $finish;
   end

endmodule

// ===== files.f =====
src/irc_fse_pkg.sv
src/irc_fse_front.sv
src/irc_fse_queue.sv
src/irc_fse_back.sv
src/irc_format_strip_escape.sv
bench/irc_format_strip_escape_test.sv
